// ----- rtl/core/fmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmf_pkg
// Shared types and constants of the fuzzy membership fuzzifier: widths,
// shape and register codes, and the records passed between the stages.
// ----------------------------------------------------------------------------
package fmf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int FRACTION_BITS   = 15;
  localparam int OUT_BITS        = FRACTION_BITS + 1;
  localparam int DIFF_BITS       = SAMPLE_BITS + 1;
  localparam int STEPS_PER_STAGE = 3;
  localparam int DIV_STAGES      = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int CFG_INDEX_BITS  = 3;

  localparam logic [OUT_BITS-1:0] FULL_ONE = OUT_BITS'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    SHAPE_TRIANGLE  = 2'd0,
    SHAPE_TRAPEZOID = 2'd1,
    SHAPE_L         = 2'd2,
    SHAPE_GAMMA     = 2'd3
  } shape_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SHAPE   = 3'd0,
    CFG_BREAK_A = 3'd1,
    CFG_BREAK_B = 3'd2,
    CFG_BREAK_C = 3'd3,
    CFG_BREAK_D = 3'd4
  } cfg_index_t;

  typedef struct packed {
    shape_t                        shape;
    logic signed [SAMPLE_BITS-1:0] break_a;
    logic signed [SAMPLE_BITS-1:0] break_b;
    logic signed [SAMPLE_BITS-1:0] break_c;
    logic signed [SAMPLE_BITS-1:0] break_d;
  } fmf_cfg_t;

  typedef struct packed {
    logic force_one;
    logic force_zero;
  } ramp_ctrl_t;

  // one slot of the divider pipeline
  typedef struct packed {
    logic                     valid;
    ramp_ctrl_t               ctrl;
    logic [SAMPLE_BITS-1:0]   rem;
    logic [SAMPLE_BITS-1:0]   den;
    logic [FRACTION_BITS-1:0] quo;
  } div_slot_t;

endpackage

// ----- rtl/core/fmf_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmf_select
// Two register stages: breakpoint differences first, then the shape rule
// that picks a ramp (numerator and denominator) or a constant degree.
// ----------------------------------------------------------------------------
module fmf_select (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [fmf_pkg::SAMPLE_BITS-1:0] sample,
  input  fmf_pkg::fmf_cfg_t                     cfg,
  output fmf_pkg::div_slot_t                    req
);
  import fmf_pkg::*;

  logic                        s1_valid;
  shape_t                      s1_shape;
  logic signed [DIFF_BITS-1:0] xa, bx, cx, dx, ba, cb, dc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_shape <= cfg.shape;
      xa <= DIFF_BITS'(sample) - DIFF_BITS'(cfg.break_a);
      bx <= DIFF_BITS'(cfg.break_b) - DIFF_BITS'(sample);
      cx <= DIFF_BITS'(cfg.break_c) - DIFF_BITS'(sample);
      dx <= DIFF_BITS'(cfg.break_d) - DIFF_BITS'(sample);
      ba <= DIFF_BITS'(cfg.break_b) - DIFF_BITS'(cfg.break_a);
      cb <= DIFF_BITS'(cfg.break_c) - DIFF_BITS'(cfg.break_b);
      dc <= DIFF_BITS'(cfg.break_d) - DIFF_BITS'(cfg.break_c);
    end
  end

  logic                        xa_neg, bx_neg, cx_neg, dx_neg;
  logic                        bx_zero, cx_zero;
  logic                        sel_ramp, sel_one;
  logic signed [DIFF_BITS-1:0] num, den;
  div_slot_t                   req_next;

  assign xa_neg  = xa[DIFF_BITS-1];
  assign bx_neg  = bx[DIFF_BITS-1];
  assign cx_neg  = cx[DIFF_BITS-1];
  assign dx_neg  = dx[DIFF_BITS-1];
  assign bx_zero = (bx == '0);
  assign cx_zero = (cx == '0);

  always_comb begin
    sel_ramp = 1'b0;
    sel_one  = 1'b0;
    num      = xa;
    den      = ba;
    case (s1_shape)
      SHAPE_TRIANGLE: begin
        if (!xa_neg && !bx_neg) begin
          sel_ramp = 1'b1;
        end else if ((bx_neg || bx_zero) && !cx_neg) begin
          sel_ramp = 1'b1;
          num      = cx;
          den      = cb;
        end
      end
      SHAPE_TRAPEZOID: begin
        if (!xa_neg && !bx_neg) begin
          sel_ramp = 1'b1;
        end else if ((cx_neg || cx_zero) && !dx_neg) begin
          sel_ramp = 1'b1;
          num      = dx;
          den      = dc;
        end else if (bx_neg && !cx_neg && !cx_zero) begin
          sel_one = 1'b1;
        end
      end
      SHAPE_L: begin
        if (!xa_neg && !bx_neg) begin
          sel_ramp = 1'b1;
          num      = bx;
        end else if (xa_neg) begin
          sel_one = 1'b1;
        end
      end
      default: begin
        if (!xa_neg && !bx_neg) begin
          sel_ramp = 1'b1;
        end else if (!xa_neg) begin
          sel_one = 1'b1;
        end
      end
    endcase
  end

  // a flat or degenerate ramp saturates at full membership
  always_comb begin
    req_next.valid           = s1_valid;
    req_next.ctrl.force_one  = sel_one || (sel_ramp && (den[DIFF_BITS-1] || (den == '0) ||
                                           num[DIFF_BITS-1] || (num >= den)));
    req_next.ctrl.force_zero = !sel_ramp && !sel_one;
    req_next.rem             = num[SAMPLE_BITS-1:0];
    req_next.den             = den[SAMPLE_BITS-1:0];
    req_next.quo             = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (adv) begin
      req <= req_next;
    end
  end

endmodule

// ----- rtl/core/fmf_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmf_divider
// Pipelined restoring divider for (num << FRACTION_BITS) / den with
// num < den, a few quotient bits per register stage.
// ----------------------------------------------------------------------------
module fmf_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  fmf_pkg::div_slot_t req,
  output fmf_pkg::div_slot_t res
);
  import fmf_pkg::*;

  div_slot_t pipe [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_slot_t cur;
    div_slot_t nxt;

    if (s == 0) begin : g_first
      assign cur = req;
    end else begin : g_rest
      assign cur = pipe[s-1];
    end

    always_comb begin
      logic [SAMPLE_BITS:0] trial;
      nxt = cur;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        trial = {nxt.rem, 1'b0};
        if (s * STEPS_PER_STAGE + k < FRACTION_BITS) begin
          if (trial >= {1'b0, nxt.den}) begin
            trial   = trial - {1'b0, nxt.den};
            nxt.quo = {nxt.quo[FRACTION_BITS-2:0], 1'b1};
          end else begin
            nxt.quo = {nxt.quo[FRACTION_BITS-2:0], 1'b0};
          end
          nxt.rem = trial[SAMPLE_BITS-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        pipe[s].valid <= 1'b0;
      end else if (adv) begin
        pipe[s] <= nxt;
      end
    end
  end

  assign res = pipe[DIV_STAGES-1];

endmodule

// ----- rtl/core/fuzzy_membership_fuzzifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_membership_fuzzifier_top
// Maps a signed sample to a Q1.15 membership degree over four breakpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel sample_valid / sample_stall carries one sample per
//   transaction; output channel membership_valid / membership_stall returns
//   one degree per sample, in order (32768 means full membership).
//   Configuration writes go through cfg_valid / cfg_ready (always ready):
//   index 0 shape, 1..4 breakpoints a..d. Write only while the pipe is empty.
//   Pipeline: eight register stages (difference, shape select, five divider
//   stages of three quotient bits each, output register). Throughput: one
//   sample per cycle while the output is not stalled, set by the pipelined
//   divider. A stall on the output while membership_valid is high freezes
//   every stage and raises sample_stall in the same cycle; nothing is
//   dropped or repeated.
//   Reset (rst, synchronous) empties the pipe, clears the shape to
//   triangular and all breakpoints to zero.
// ----------------------------------------------------------------------------
module fuzzy_membership_fuzzifier_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     sample_valid,
  output logic                                     sample_stall,
  input  logic signed [fmf_pkg::SAMPLE_BITS-1:0]    sample,
  output logic                                     membership_valid,
  input  logic                                     membership_stall,
  output logic [fmf_pkg::OUT_BITS-1:0]             membership,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [fmf_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [fmf_pkg::SAMPLE_BITS-1:0]          cfg_data
);
  import fmf_pkg::*;

  fmf_cfg_t  cfg;
  div_slot_t req;
  div_slot_t res;
  logic      adv;

  assign adv          = !(membership_valid && membership_stall);
  assign sample_stall = !adv;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape   <= SHAPE_TRIANGLE;
      cfg.break_a <= '0;
      cfg.break_b <= '0;
      cfg.break_c <= '0;
      cfg.break_d <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHAPE:   cfg.shape   <= shape_t'(cfg_data[1:0]);
        CFG_BREAK_A: cfg.break_a <= cfg_data;
        CFG_BREAK_B: cfg.break_b <= cfg_data;
        CFG_BREAK_C: cfg.break_c <= cfg_data;
        CFG_BREAK_D: cfg.break_d <= cfg_data;
        default: ;
      endcase
    end
  end

  fmf_select u_select (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sample_valid),
    .sample   (sample),
    .cfg      (cfg),
    .req      (req)
  );

  fmf_divider u_divider (
    .clk (clk),
    .rst (rst),
    .adv (adv),
    .req (req),
    .res (res)
  );

  logic [OUT_BITS-1:0] membership_next;

  always_comb begin
    if (res.ctrl.force_one) begin
      membership_next = FULL_ONE;
    end else if (res.ctrl.force_zero) begin
      membership_next = '0;
    end else begin
      membership_next = {1'b0, res.quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      membership_valid <= 1'b0;
    end else if (adv) begin
      membership_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      membership <= membership_next;
    end
  end

`ifndef SYNTHESIS
  a_degree_in_range: assert property (@(posedge clk) disable iff (rst)
    membership_valid |-> membership <= FULL_ONE)
    else $error("membership above full scale");

  a_ctrl_exclusive: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.ctrl.force_one && res.ctrl.force_zero))
    else $error("divider slot marked both full and empty");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ctrl.force_one && !res.ctrl.force_zero) |-> res.rem < res.den)
    else $error("divider remainder not below denominator");

  a_stall_freezes_out: assert property (@(posedge clk) disable iff (rst)
    (membership_valid && membership_stall) |=> membership_valid && $stable(membership))
    else $error("output changed while stalled");
`endif

endmodule

// ----- dv/fuzzy_membership_fuzzifier_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_membership_fuzzifier_top_test
// Self-checking bench for the fuzzifier. Streams signed samples through the
// pipe under several shape and breakpoint settings, with random idling on
// both channels and a long output hold-off. A scoreboard predicts each Q1.15
// degree and compares it, in order, with what comes out.
// ----------------------------------------------------------------------------
module fuzzy_membership_fuzzifier_top_test;
  import fmf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 150;
  localparam int NUM_PHASES   = 20;
  localparam int HOLD_PHASE   = 6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 3'd5;

  localparam int EDGE_SAMPLES[5]  = '{-32768, -1, 0, 1, 32767};
  localparam int SHAPE_PROBES[5]  = '{-101, -33, 0, 67, 150};
  localparam int PROBE_BREAKS[4]  = '{-100, 0, 100, 200};

  class membership_scoreboard;
    shape_t                        shape;
    logic signed [SAMPLE_BITS-1:0] brk_a;
    logic signed [SAMPLE_BITS-1:0] brk_b;
    logic signed [SAMPLE_BITS-1:0] brk_c;
    logic signed [SAMPLE_BITS-1:0] brk_d;
    logic [OUT_BITS-1:0]           degree_q[$];
    int unsigned                   mismatches;

    function new();
      shape      = SHAPE_TRIANGLE;
      brk_a      = '0;
      brk_b      = '0;
      brk_c      = '0;
      brk_d      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [SAMPLE_BITS-1:0] data);
      case (idx)
        CFG_SHAPE:   shape = shape_t'(data[1:0]);
        CFG_BREAK_A: brk_a = data;
        CFG_BREAK_B: brk_b = data;
        CFG_BREAK_C: brk_c = data;
        CFG_BREAK_D: brk_d = data;
        default: ;
      endcase
    endfunction

    // zero-width ramp means the sample sits on its single point: full membership
    function logic [OUT_BITS-1:0] ramp_degree(longint rise, longint span);
      if (span <= 0 || rise < 0 || rise >= span) return FULL_ONE;
      return OUT_BITS'((rise << FRACTION_BITS) / span);
    endfunction

    function logic [OUT_BITS-1:0] degree_of(logic signed [SAMPLE_BITS-1:0] x);
      longint xv, a, b, c, d;
      xv = x;
      a  = brk_a;
      b  = brk_b;
      c  = brk_c;
      d  = brk_d;
      case (shape)
        SHAPE_TRIANGLE: begin
          if (xv >= a && xv <= b) return ramp_degree(xv - a, b - a);
          if (xv >= b && xv <= c) return ramp_degree(c - xv, c - b);
          return '0;
        end
        SHAPE_TRAPEZOID: begin
          if (xv >= a && xv <= b) return ramp_degree(xv - a, b - a);
          if (xv >= c && xv <= d) return ramp_degree(d - xv, d - c);
          if (xv > b && xv < c) return FULL_ONE;
          return '0;
        end
        SHAPE_L: begin
          if (xv >= a && xv <= b) return ramp_degree(b - xv, b - a);
          if (xv < a) return FULL_ONE;
          return '0;
        end
        default: begin
          if (xv >= a && xv <= b) return ramp_degree(xv - a, b - a);
          if (xv < a) return '0;
          return FULL_ONE;
        end
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] x);
      degree_q.push_back(degree_of(x));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_membership(logic [OUT_BITS-1:0] got);
      logic [OUT_BITS-1:0] want;
      if (degree_q.size() == 0) begin
        report($sformatf("membership %0d with no sample outstanding", got));
        return;
      end
      want = degree_q.pop_front();
      if (got !== want) report($sformatf("membership %0d, predicted %0d", got, want));
    endtask
  endclass

  logic                          clk;
  logic                          rst;
  logic                          sample_valid;
  logic                          sample_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          membership_valid;
  logic                          membership_stall;
  logic [OUT_BITS-1:0]           membership;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index;
  logic [SAMPLE_BITS-1:0]        cfg_data;

  membership_scoreboard sb;
  int unsigned          cycle_count = 0;
  int                   hold_request = 0;
  int                   rx_stall_left = 0;
  bit                   rx_idling = 0;

  fuzzy_membership_fuzzifier_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .membership_valid (membership_valid),
    .membership_stall (membership_stall),
    .membership       (membership),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // every transaction seen on the three channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
      if (sample_valid && !sample_stall) sb.note_sample(sample);
      if (membership_valid && !membership_stall) sb.check_membership(membership);
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    membership_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_stall_left == 0) begin
        if (hold_request > 0) begin
          rx_stall_left = hold_request;
          hold_request  = 0;
        end else if (rx_idling && $urandom_range(0, 5) == 0) begin
          rx_stall_left = $urandom_range(1, 8);
        end
      end
      membership_stall = (rx_stall_left > 0);
      if (rx_stall_left > 0) rx_stall_left--;
    end
  end

  task automatic put_sample(logic [SAMPLE_BITS-1:0] x);
    @(negedge clk);
    sample_valid = 1'b1;
    sample       = x;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic sender_gap(int cycles);
    @(negedge clk);
    sample_valid = 1'b0;
    sample       = 16'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait for the pipe to empty before touching the registers
  task automatic settle();
    @(negedge clk);
    sample_valid = 1'b0;
    while (sb.degree_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [SAMPLE_BITS-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // mostly around the breakpoints, some anywhere and at the range ends
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int pts[4];
    int lo, hi;
    pts = '{sb.brk_a, sb.brk_b, sb.brk_c, sb.brk_d};
    lo  = pts[0];
    hi  = pts[0];
    foreach (pts[k]) begin
      if (pts[k] < lo) lo = pts[k];
      if (pts[k] > hi) hi = pts[k];
    end
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      3, 4, 5: return 16'(pts[$urandom_range(0, 3)] + int'($urandom_range(0, 6)) - 3);
      default: return 16'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  initial begin
    int               brk[4];
    int               base;
    int               n_items;
    bit               tx_idling;
    shape_t           s;
    logic [SAMPLE_BITS-1:0] word;

    sb           = new();
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset config: every ramp has zero width at the origin
    foreach (EDGE_SAMPLES[k]) put_sample(16'(EDGE_SAMPLES[k]));

    s = s.first();
    do begin
      settle();
      write_cfg(CFG_SHAPE, 16'(s));
      if (s == s.first()) begin
        write_cfg(CFG_BREAK_A, 16'(PROBE_BREAKS[0]));
        write_cfg(CFG_BREAK_B, 16'(PROBE_BREAKS[1]));
        write_cfg(CFG_BREAK_C, 16'(PROBE_BREAKS[2]));
        write_cfg(CFG_BREAK_D, 16'(PROBE_BREAKS[3]));
      end
      foreach (SHAPE_PROBES[k]) put_sample(16'(SHAPE_PROBES[k]));
      s = s.next();
    end while (s != s.first());

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      if (ph == 0) brk = '{-32768, 32767, 32767, 32767};
      else if (ph == 1) brk = '{-32768, -32768, 32767, 32767};
      else if (ph == 2) brk = '{32767, 32767, -32768, -32768};
      else begin
        foreach (brk[k]) brk[k] = $signed(16'($urandom));
        case ($urandom_range(0, 3))
          0: begin
            // tight cluster, zero-width ramps are likely
            base = int'($urandom_range(0, 64768)) - 32768;
            foreach (brk[k]) begin
              base   = base + int'($urandom_range(0, 12));
              brk[k] = base;
            end
          end
          1, 2: brk.sort();
          default: ;
        endcase
      end

      word = 16'($urandom);
      word[1:0] = (ph < 8) ? 2'(shape_t'(ph % 4)) : 2'($urandom_range(0, 3));
      write_cfg(CFG_SHAPE, word);
      if (ph < 3 || $urandom_range(0, 4) != 0) write_cfg(CFG_BREAK_A, 16'(brk[0]));
      if (ph < 3 || $urandom_range(0, 4) != 0) write_cfg(CFG_BREAK_B, 16'(brk[1]));
      if (ph < 3 || $urandom_range(0, 4) != 0) write_cfg(CFG_BREAK_C, 16'(brk[2]));
      if (ph < 3 || $urandom_range(0, 4) != 0) write_cfg(CFG_BREAK_D, 16'(brk[3]));
      if ($urandom_range(0, 3) == 0)
        write_cfg(CFG_SPARE_INDEX + CFG_INDEX_BITS'($urandom_range(0, 2)), 16'($urandom));

      tx_idling = (ph < NUM_PHASES - 3) && ($urandom_range(0, 3) != 0);
      rx_idling = (ph < NUM_PHASES - 3) && ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) begin
        // sender keeps pushing so the pipe backs up into the input
        tx_idling    = 1'b0;
        hold_request = LONG_HOLD;
      end

      n_items = $urandom_range(50, 80);
      for (int i = 0; i < n_items; i++) begin
        if (tx_idling && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 8));
        put_sample(pick_sample());
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
